@@ hdl/brd_pkg.sv @@
// brd_pkg: shared types and constants for the bridge response deframer
// no dependencies; imported by bridge_response_deframer
`default_nettype none

package brd_pkg;

   localparam int MAX_FRAME_DEF = 64;
   localparam int HEADER_BYTES  = 3;

   localparam logic [7:0] CODE_TIMEOUT = 8'h10;
   localparam logic [7:0] CODE_ERROR   = 8'h11;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_BAD_LENGTH     = 3'd1,
      ST_ID_MISMATCH    = 3'd2,
      ST_REMOTE_TIMEOUT = 3'd3,
      ST_REMOTE_ERROR   = 3'd4,
      ST_OVER_CAPACITY  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_LEN_HIGH = 2'd1,
      PH_ID       = 2'd2,
      PH_PAYLOAD  = 2'd3
   } phase_type;

endpackage

`default_nettype wire

@@ hdl/bridge_response_deframer.sv @@
// bridge_response_deframer: parses length/id framed response words, one word per cycle while req_ready is high
// an accepted word's result is registered in the output register
// throughput: one word per cycle while the output register is empty or rsp_ready takes it
// reset (synchronous, active high) returns the parser to waiting for a frame start
// and empties the output register
// depends on brd_pkg
`default_nettype none

module bridge_response_deframer #(
   parameter int MaxFrame = brd_pkg::MAX_FRAME_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [7:0]              req_rx_byte,
   input  wire logic                    req_frame_start,
   input  wire logic [7:0]              req_match_id,
   input  wire logic [5:0]              req_payload_capacity,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic [7:0]              rsp_data_byte,
   output      logic                    rsp_has_data,
   output      logic                    rsp_frame_end,
   output      brd_pkg::status_type     rsp_status
);
   import brd_pkg::*;

   localparam int LEN_W = $clog2(MaxFrame + 1);
   localparam int CMP_W = (LEN_W > 6) ? LEN_W : 6;
   localparam logic [15:0] MAX16 = 16'(MaxFrame);
   localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);

   phase_type          phase_ff, phase_in;
   logic [7:0]         length_low_ff, length_low_in;
   logic [LEN_W-1:0]   declared_length_ff, declared_length_in;
   logic [LEN_W-1:0]   bytes_seen_ff, bytes_seen_in;
   status_type         pending_status_ff, pending_status_in;
   logic               pass_payload_ff, pass_payload_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_has_ff, rsp_has_in;
   logic               rsp_end_ff, rsp_end_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               accept;
   logic [15:0]        new_len;
   logic               len_bad;
   logic [LEN_W-1:0]   plen;
   logic               over_cap;
   status_type         id_status;
   logic [LEN_W:0]     seen_next;
   logic               last;
   logic               single;
   logic               remote;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign new_len   = {req_rx_byte, length_low_ff};
   assign len_bad   = (new_len < HDR16) || (new_len > MAX16);
   // declared length is at least the header once the id word arrives
   assign plen      = declared_length_ff - LEN_W'(HEADER_BYTES);
   assign over_cap  = CMP_W'(plen) > CMP_W'(req_payload_capacity);
   assign id_status = (req_rx_byte != req_match_id) ? ST_ID_MISMATCH :
                      over_cap ? ST_OVER_CAPACITY : ST_OK;
   assign seen_next = {1'b0, bytes_seen_ff} + (LEN_W+1)'(1);
   assign last      = seen_next >= {1'b0, declared_length_ff};
   assign single    = declared_length_ff == LEN_W'(HEADER_BYTES + 1);
   // one-word payload carrying a remote code overrides capacity
   assign remote    = single && (pending_status_ff != ST_ID_MISMATCH) &&
                      ((req_rx_byte == CODE_TIMEOUT) || (req_rx_byte == CODE_ERROR));

   // parser next state
   always_comb begin
      phase_in           = phase_ff;
      length_low_in      = length_low_ff;
      declared_length_in = declared_length_ff;
      bytes_seen_in      = bytes_seen_ff;
      pending_status_in  = pending_status_ff;
      pass_payload_in    = pass_payload_ff;
      if (accept) begin
         if (req_frame_start) begin
            length_low_in     = req_rx_byte;
            bytes_seen_in     = LEN_W'(1);
            pending_status_in = ST_OK;
            pass_payload_in   = 1'b0;
            phase_in          = PH_LEN_HIGH;
         end else begin
            case (phase_ff)
               PH_LEN_HIGH: begin
                  bytes_seen_in = LEN_W'(2);
                  if (len_bad) begin
                     phase_in = PH_IDLE;
                  end else begin
                     declared_length_in = LEN_W'(new_len);
                     phase_in           = PH_ID;
                  end
               end
               PH_ID: begin
                  bytes_seen_in     = LEN_W'(3);
                  pending_status_in = id_status;
                  pass_payload_in   = (id_status == ST_OK);
                  phase_in          = (plen == '0) ? PH_IDLE : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  bytes_seen_in = seen_next[LEN_W-1:0];
                  if (last) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // result for the accepted word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b0;
         rsp_data_in   = 8'd0;
         rsp_has_in    = 1'b0;
         rsp_end_in    = 1'b1;
         rsp_status_in = ST_OK;
         if (!req_frame_start) begin
            case (phase_ff)
               PH_LEN_HIGH: begin
                  rsp_valid_in  = len_bad;
                  rsp_status_in = ST_BAD_LENGTH;
               end
               PH_ID: begin
                  rsp_valid_in  = (plen == '0);
                  rsp_status_in = id_status;
               end
               PH_PAYLOAD: begin
                  if (remote) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = (req_rx_byte == CODE_TIMEOUT) ?
                                     ST_REMOTE_TIMEOUT : ST_REMOTE_ERROR;
                  end else if (pass_payload_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = req_rx_byte;
                     rsp_has_in   = 1'b1;
                     rsp_end_in   = last;
                  end else begin
                     rsp_valid_in  = last;
                     rsp_status_in = pending_status_ff;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         length_low_ff      <= 8'd0;
         declared_length_ff <= '0;
         bytes_seen_ff      <= '0;
         pending_status_ff  <= ST_OK;
         pass_payload_ff    <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         length_low_ff      <= length_low_in;
         declared_length_ff <= declared_length_in;
         bytes_seen_ff      <= bytes_seen_in;
         pending_status_ff  <= pending_status_in;
         pass_payload_ff    <= pass_payload_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_has_data  = rsp_has_ff;
   assign rsp_frame_end = rsp_end_ff;
   assign rsp_status    = rsp_status_ff;

   // status only travels with the end of a frame
   a_status_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_status == ST_OK)
      else $error("status without frame end");

   // passed payload always means the checks succeeded
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |-> rsp_status == ST_OK)
      else $error("payload word with error status");

   // payload count stays inside the declared frame
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_seen_ff < declared_length_ff)
      else $error("payload count past declared length");

   // a bad length closes the frame at once
   a_bad_len_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !req_frame_start && phase_ff == PH_LEN_HIGH && len_bad
      |=> phase_ff == PH_IDLE && rsp_valid && rsp_status == ST_BAD_LENGTH)
      else $error("bad length not reported");

endmodule

`default_nettype wire
